// ===== hw/rtl/ltd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared types and constants for the largest-triangle downsampler.
// ----------------------------------------------------------------------------
package ltd_pkg;

  localparam int COORD_W  = 24;
  localparam int CNT_W    = 17;   // point / target counts, 17 bits; point count capped at 65536
  localparam int IDX_W    = 16;   // index of a point within a series
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int AREA_W   = PROD_W + 1;
  localparam int ACC_W    = 2 * CNT_W;

  localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(65536);
  localparam logic [CNT_W-1:0] MIN_TARGET = CNT_W'(3);

  localparam int IN_W  = 2 * COORD_W;
  localparam int OUT_W = 2 * COORD_W + IDX_W;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = CNT_W;
  localparam logic [CFG_AW-1:0] REG_POINT_COUNT  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_TARGET_COUNT = CFG_AW'(1);

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam int CREDIT_W   = FIFO_CW + 1;

  typedef struct packed {
    logic                      last;
    logic [IDX_W-1:0]          index;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } result_t;

  // up to two results pushed per cycle, first one goes out first
  typedef struct packed {
    logic    en0;
    logic    en1;
    result_t r0;
    result_t r1;
  } fifo_wr_t;

endpackage

// ===== hw/rtl/ltd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ltd_out_fifo
// Result queue: takes up to two items per cycle, hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module ltd_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  ltd_pkg::fifo_wr_t               wr,
  output logic                            rd_valid,
  input  logic                            rd_ready,
  output ltd_pkg::result_t                rd_data,
  output logic [ltd_pkg::FIFO_CW-1:0]     count
);

  ltd_pkg::result_t                   mem [ltd_pkg::FIFO_DEPTH];
  logic [ltd_pkg::FIFO_AW-1:0]        wp;
  logic [ltd_pkg::FIFO_AW-1:0]        rp;
  logic                               pop;
  logic [ltd_pkg::FIFO_CW-1:0]        push_n;

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  assign pop      = rd_valid && rd_ready;
  assign push_n   = ltd_pkg::FIFO_CW'(wr.en0) + ltd_pkg::FIFO_CW'(wr.en1);

  always_ff @(posedge clk) begin
    if (wr.en0 && wr.en1) begin
      mem[wp]                                  <= wr.r0;
      mem[wp + ltd_pkg::FIFO_AW'(1)]           <= wr.r1;
    end else if (wr.en0) begin
      mem[wp] <= wr.r0;
    end else if (wr.en1) begin
      mem[wp] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_n[ltd_pkg::FIFO_AW-1:0];
      if (pop) begin
        rp <= rp + ltd_pkg::FIFO_AW'(1);
      end
      count <= count + push_n - ltd_pkg::FIFO_CW'(pop);
    end
  end

endmodule

// ===== hw/rtl/largest_triangle_downsampler.sv =====
// ----------------------------------------------------------------------------
// largest_triangle_downsampler
// Largest-triangle-one-bucket reduction of a point stream.
// ----------------------------------------------------------------------------
// Takes one point per cycle and keeps the first, the last and, from every inner
// bucket, the point spanning the largest triangle with its input neighbors.
// A point passes a three-register path: the input stage (counters, bucket
// bounds, coordinate differences), the multiplier stage (two 25x25 products)
// and the decision stage (area, running best, queue write). A result reaches the
// output after its point has passed all three and entered the queue. Bucket
// bounds are tracked incrementally as i*D against the running (b+1)*S, so no
// divider is involved. Results sit in an 8-entry queue; s_axis_tready holds
// off when the queue fill plus room reserved for points still in flight
// (two results each) would overflow it, which with a ready sink never happens.
// The final point of a bucketed series gives two results in one cycle.
// Writing a configuration register restarts the series.
module largest_triangle_downsampler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ltd_pkg::IN_W-1:0]      s_axis_tdata,   // x_coord, y_coord
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ltd_pkg::OUT_W-1:0]     m_axis_tdata,   // out_x, out_y, out_index
  output logic                          m_axis_tlast,
  input  logic                          cfg_wr_en,
  input  logic [ltd_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [ltd_pkg::CFG_DW-1:0]    cfg_wdata
);

  typedef struct packed {
    logic emit_pt;     // pass-through or first point
    logic pt_last;
    logic first;       // opens a bucketed series, clears the best
    logic in_bucket;
    logic close;       // bucket ends with this point
    logic emit_last;   // bucketed series ends here
  } ctrl_t;

  // ---------------- configuration ----------------
  logic [ltd_pkg::CNT_W-1:0] point_count;
  logic [ltd_pkg::CNT_W-1:0] target_count;
  logic                      cfg_restart;

  assign cfg_restart = cfg_wr_en && ((cfg_addr == ltd_pkg::REG_POINT_COUNT) ||
                                     (cfg_addr == ltd_pkg::REG_TARGET_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      target_count <= ltd_pkg::MIN_TARGET;
    end else if (cfg_wr_en) begin
      if (cfg_addr == ltd_pkg::REG_POINT_COUNT) begin
        point_count <= cfg_wdata;
      end else if (cfg_addr == ltd_pkg::REG_TARGET_COUNT) begin
        target_count <= cfg_wdata;
      end
    end
  end

  // ---------------- input stage ----------------
  logic [ltd_pkg::CNT_W-1:0] n_eff;
  logic [ltd_pkg::CNT_W-1:0] t_eff;
  logic [ltd_pkg::CNT_W-1:0] d_val;
  logic [ltd_pkg::CNT_W-1:0] s_val;
  logic                      pass_mode;
  logic                      last_pt;
  logic                      accept;
  logic                      live;
  ctrl_t                     ctrl;

  logic [ltd_pkg::CNT_W-1:0] pcnt;   // index of the next point
  logic [ltd_pkg::ACC_W-1:0] acc;    // (b+1)*S while bucket b is open
  logic [ltd_pkg::ACC_W-1:0] pd;     // pcnt*D
  logic [ltd_pkg::ACC_W-1:0] pd_plus;

  logic signed [ltd_pkg::COORD_W-1:0] in_x, in_y;
  logic signed [ltd_pkg::COORD_W-1:0] xp, yp, xc, yc;

  assign in_x = s_axis_tdata[ltd_pkg::COORD_W-1:0];
  assign in_y = s_axis_tdata[ltd_pkg::IN_W-1:ltd_pkg::COORD_W];

  always_comb begin
    n_eff     = (point_count > ltd_pkg::MAX_POINTS) ? ltd_pkg::MAX_POINTS : point_count;
    t_eff     = (target_count < ltd_pkg::MIN_TARGET) ? ltd_pkg::MIN_TARGET : target_count;
    d_val     = t_eff - ltd_pkg::CNT_W'(2);
    s_val     = n_eff - ltd_pkg::CNT_W'(2);
    pass_mode = (t_eff >= n_eff) || (n_eff <= ltd_pkg::CNT_W'(2));
    last_pt   = (pcnt == n_eff - ltd_pkg::CNT_W'(1));
    pd_plus   = pd + ltd_pkg::ACC_W'(d_val);

    ctrl           = '0;
    if (pass_mode) begin
      ctrl.emit_pt = 1'b1;
      ctrl.pt_last = last_pt;
    end else if (pcnt == '0) begin
      ctrl.emit_pt = 1'b1;
      ctrl.first   = 1'b1;
    end else begin
      // j = pcnt-1 lies in a bucket once pcnt*D > S
      ctrl.in_bucket = (pd > ltd_pkg::ACC_W'(s_val));
      // bucket ends when (j+2)*D > (b+1)*S, or at the series end
      ctrl.close     = ctrl.in_bucket && ((pd_plus > acc) || last_pt);
      ctrl.emit_last = last_pt;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign live   = accept && (n_eff != '0);

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      pcnt <= '0;
      acc  <= '0;
      pd   <= '0;
    end else if (live) begin
      if (last_pt) begin
        pcnt <= '0;
        acc  <= '0;
        pd   <= '0;
      end else begin
        pcnt <= pcnt + ltd_pkg::CNT_W'(1);
        pd   <= pd_plus;
        if (ctrl.first) begin
          acc <= ltd_pkg::ACC_W'({s_val, 1'b0});
        end else if (ctrl.close) begin
          acc <= acc + ltd_pkg::ACC_W'(s_val);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xp <= '0;
      yp <= '0;
      xc <= '0;
      yc <= '0;
    end else if (live) begin
      xp <= xc;
      yp <= yc;
      xc <= in_x;
      yc <= in_y;
    end
  end

  logic                               s1_valid;
  ctrl_t                              s1_ctrl;
  logic signed [ltd_pkg::DIFF_W-1:0]  s1_d1, s1_d2, s1_d3, s1_d4;
  logic signed [ltd_pkg::COORD_W-1:0] s1_x, s1_y, s1_xc, s1_yc;
  logic [ltd_pkg::IDX_W-1:0]          s1_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (live) begin
      s1_ctrl <= ctrl;
      s1_d1   <= ltd_pkg::DIFF_W'(xp) - ltd_pkg::DIFF_W'(in_x);
      s1_d2   <= ltd_pkg::DIFF_W'(yc) - ltd_pkg::DIFF_W'(yp);
      s1_d3   <= ltd_pkg::DIFF_W'(xp) - ltd_pkg::DIFF_W'(xc);
      s1_d4   <= ltd_pkg::DIFF_W'(in_y) - ltd_pkg::DIFF_W'(yp);
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_xc   <= xc;
      s1_yc   <= yc;
      s1_idx  <= pcnt[ltd_pkg::IDX_W-1:0];
    end
  end

  // ---------------- multiplier stage ----------------
  logic                               s2_valid;
  ctrl_t                              s2_ctrl;
  logic signed [ltd_pkg::PROD_W-1:0]  s2_p1, s2_p2;
  logic signed [ltd_pkg::COORD_W-1:0] s2_x, s2_y, s2_xc, s2_yc;
  logic [ltd_pkg::IDX_W-1:0]          s2_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_ctrl <= s1_ctrl;
      s2_p1   <= s1_d1 * s1_d2;
      s2_p2   <= s1_d3 * s1_d4;
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_xc   <= s1_xc;
      s2_yc   <= s1_yc;
      s2_idx  <= s1_idx;
    end
  end

  // ---------------- decision stage ----------------
  logic signed [ltd_pkg::AREA_W-1:0]  area_s;
  logic [ltd_pkg::AREA_W-1:0]         area;
  logic                               upd;
  logic                               best_valid;
  logic [ltd_pkg::AREA_W-1:0]         best_area;
  logic signed [ltd_pkg::COORD_W-1:0] best_x, best_y;
  logic [ltd_pkg::IDX_W-1:0]          best_index;
  ltd_pkg::result_t                   best_res;
  ltd_pkg::result_t                   pt_res;
  ltd_pkg::fifo_wr_t                  fwr;

  always_comb begin
    area_s = ltd_pkg::AREA_W'(s2_p1) - ltd_pkg::AREA_W'(s2_p2);
    area   = area_s[ltd_pkg::AREA_W-1] ? ltd_pkg::AREA_W'(-area_s)
                                       : ltd_pkg::AREA_W'(area_s);
    // ties keep the earlier point
    upd    = s2_ctrl.in_bucket && (!best_valid || (area > best_area));

    best_res.x     = upd ? s2_xc  : best_x;
    best_res.y     = upd ? s2_yc  : best_y;
    best_res.index = upd ? (s2_idx - ltd_pkg::IDX_W'(1)) : best_index;
    best_res.last  = 1'b0;

    pt_res.x     = s2_x;
    pt_res.y     = s2_y;
    pt_res.index = s2_idx;
    pt_res.last  = s2_ctrl.pt_last;

    fwr.en0       = s2_valid && (s2_ctrl.emit_pt || s2_ctrl.close);
    fwr.r0        = s2_ctrl.emit_pt ? pt_res : best_res;
    fwr.en1       = s2_valid && s2_ctrl.emit_last;
    fwr.r1        = pt_res;
    fwr.r1.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_area  <= '0;
    end else if (s2_valid) begin
      if (s2_ctrl.first || s2_ctrl.close) begin
        best_valid <= 1'b0;
        best_area  <= '0;
      end else if (upd) begin
        best_valid <= 1'b1;
        best_area  <= area;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && upd) begin
      best_x     <= best_res.x;
      best_y     <= best_res.y;
      best_index <= best_res.index;
    end
  end

  // ---------------- result queue ----------------
  logic [ltd_pkg::FIFO_CW-1:0]  fcount;
  logic [ltd_pkg::CREDIT_W-1:0] credit_used;
  ltd_pkg::result_t             rd_res;

  ltd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (fwr),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (rd_res),
    .count    (fcount)
  );

  // queue fill plus two slots for each point still in the pipe
  assign credit_used = ltd_pkg::CREDIT_W'(fcount)
                     + ltd_pkg::CREDIT_W'({s1_valid, 1'b0})
                     + ltd_pkg::CREDIT_W'({s2_valid, 1'b0});
  assign s_axis_tready = (credit_used + ltd_pkg::CREDIT_W'(2))
                         <= ltd_pkg::CREDIT_W'(ltd_pkg::FIFO_DEPTH);

  assign m_axis_tdata = {rd_res.index, rd_res.y, rd_res.x};
  assign m_axis_tlast = rd_res.last;

  // ---------------- assertions ----------------
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    credit_used <= ltd_pkg::CREDIT_W'(ltd_pkg::FIFO_DEPTH))
    else $error("result queue reservation exceeds depth");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    (n_eff != '0) |-> (pcnt < n_eff))
    else $error("point counter beyond series length");

  a_counter_idle: assert property (@(posedge clk) disable iff (rst)
    (n_eff == '0) |-> (pcnt == '0))
    else $error("point counter moved with empty series");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ctrl.emit_last) |-> s1_ctrl.close)
    else $error("series ended without closing its bucket");

endmodule
